[hdl/sccs_pkg.sv]
// ----------------------------------------------------------------------------
// Stroke code candidate selector package
// Shared widths, operation and status codes, and the stored entry types.
// ----------------------------------------------------------------------------
package sccs_pkg;

  localparam int DICT_DEPTH   = 4096;
  localparam int DICT_AW      = $clog2(DICT_DEPTH);
  localparam int CNT_W        = DICT_AW + 1;
  localparam int MAX_CODE_LEN = 16;
  localparam int LEN_W        = 5;
  localparam int SYM_W        = 3;
  localparam int CODE_W       = SYM_W * MAX_CODE_LEN;
  localparam int WORD_W       = 32;
  localparam int FREQ_W       = 16;
  localparam int PAGE_W       = 9;
  localparam int PAGE_SIZE    = 10;

  // Reciprocal of ten for values below 4096: (x * 3277) >> 15.
  localparam int DIV10_MUL    = 3277;
  localparam int DIV10_SHIFT  = 15;

  localparam logic [SYM_W-1:0] SYM_WILD = 3'd5;

  // Operation codes.
  localparam logic [3:0] OP_LOAD   = 4'd0;
  localparam logic [3:0] OP_STROKE = 4'd1;
  localparam logic [3:0] OP_BACK   = 4'd2;
  localparam logic [3:0] OP_COMMIT = 4'd3;
  localparam logic [3:0] OP_DIGIT  = 4'd4;
  localparam logic [3:0] OP_NEXT   = 4'd5;
  localparam logic [3:0] OP_PRIOR  = 4'd6;
  localparam logic [3:0] OP_DOWN   = 4'd7;
  localparam logic [3:0] OP_UP     = 4'd8;
  localparam logic [3:0] OP_READ   = 4'd9;

  // Status codes.
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_DROPPED = 2'd2;

  // One dictionary entry as stored.
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
    logic [FREQ_W-1:0] freq;
  } dict_entry_t;

  // One candidate list entry: sort key and dictionary index.
  typedef struct packed {
    logic [FREQ_W-1:0]  freq;
    logic [DICT_AW-1:0] idx;
  } cand_entry_t;

endpackage

[hdl/stroke_code_candidate_selector.sv]
// ----------------------------------------------------------------------------
// Stroke code candidate selector
// Dictionary of stroke coded words with wildcard prefix search, frequency
// ordered candidate list, paging, selection and commit.
// ----------------------------------------------------------------------------
// One transaction is taken when start_i is high and busy_o is low; its result
// appears for exactly one cycle with done_o high and cannot be held off, so it
// must be captured in that cycle. Load, paging, selection and status-only
// operations finish in the cycle after they are taken. Commit and read pass
// through S_LK1, S_LK2 and S_LK3: a candidate list read, then a dictionary
// read. A stroke, or a backspace that leaves a non-empty code, first sweeps
// the dictionary memory once and compares every loaded entry; with more than
// one match, a stable radix-2 sort on the 16-bit frequency makes two sweeps
// per key bit between two ping-pong list memories.
module stroke_code_candidate_selector (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  output logic                           done_o,
  input  logic [3:0]                     op_i,
  input  logic [2:0]                     stroke_i,
  input  logic [3:0]                     digit_i,
  input  logic [sccs_pkg::WORD_W-1:0]    entry_word_i,
  input  logic [sccs_pkg::CODE_W-1:0]    entry_code_i,
  input  logic [sccs_pkg::LEN_W-1:0]     entry_code_len_i,
  input  logic [sccs_pkg::FREQ_W-1:0]    entry_freq_i,
  input  logic [sccs_pkg::DICT_AW-1:0]   read_index_i,
  output logic                           commit_valid_o,
  output logic [sccs_pkg::WORD_W-1:0]    commit_word_o,
  output logic                           delete_last_o,
  output logic [sccs_pkg::CNT_W-1:0]     candidate_count_o,
  output logic [sccs_pkg::DICT_AW-1:0]   selected_index_o,
  output logic [sccs_pkg::PAGE_W-1:0]    current_page_o,
  output logic [sccs_pkg::LEN_W-1:0]     code_length_o,
  output logic [sccs_pkg::WORD_W-1:0]    read_word_o,
  output logic [1:0]                     status_o
);
  import sccs_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_SORT = 3'd2;
  localparam logic [2:0] S_LK1  = 3'd3;
  localparam logic [2:0] S_LK2  = 3'd4;
  localparam logic [2:0] S_LK3  = 3'd5;

  // Memories.
  dict_entry_t dict_mem [DICT_DEPTH];
  cand_entry_t a_mem    [DICT_DEPTH];
  cand_entry_t b_mem    [DICT_DEPTH];
  dict_entry_t dict_rd_q;
  cand_entry_t a_rd_q, b_rd_q;

  // Control and architectural state.
  logic [2:0]          state_q;
  logic                done_q;
  logic [CNT_W-1:0]    dict_count_q;
  logic [CODE_W-1:0]   typed_code_q;
  logic [LEN_W-1:0]    typed_len_q;
  logic [CNT_W-1:0]    cand_count_q;
  logic [PAGE_W-1:0]   page_q;
  logic [DICT_AW-1:0]  sel_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [CNT_W-1:0]    wp_q;
  logic                vld_q;
  logic [DICT_AW-1:0]  vidx_q;
  logic [3:0]          pass_q;
  logic                ph_q;
  logic [DICT_AW-1:0]  pos_q;
  logic                is_commit_q;

  // Result registers.
  logic                cvalid_q;
  logic [WORD_W-1:0]   cword_q;
  logic                del_q;
  logic [WORD_W-1:0]   rword_q;
  logic [1:0]          status_q;

  // Sequencer helpers.
  logic                issue;
  logic                match;
  logic                load_ok;
  logic                dict_we;
  logic                a_we, b_we;
  logic [DICT_AW-1:0]  a_raddr;
  logic [DICT_AW-1:0]  a_waddr;
  cand_entry_t         a_wdata, b_wdata, src_data;
  logic [DICT_AW-1:0]  dict_raddr;
  logic                sort_bit;

  // Selection arithmetic.
  logic [DICT_AW-1:0]  down_sel, up_sel;
  logic [DICT_AW+11:0] down_prod, up_prod;
  logic [PAGE_W:0]     next_page;
  logic [PAGE_W+4:0]   next_base;
  logic [PAGE_W+4:0]   page_base;
  logic [PAGE_W+4:0]   digit_idx;
  logic [CODE_W-1:0]   stroke_code;
  logic [CODE_W-1:0]   back_code;
  logic [LEN_W-1:0]    back_len;

  assign busy_o            = (state_q != S_IDLE);
  assign done_o            = done_q;
  assign commit_valid_o    = cvalid_q;
  assign commit_word_o     = cword_q;
  assign delete_last_o     = del_q;
  assign candidate_count_o = cand_count_q;
  assign selected_index_o  = sel_q;
  assign current_page_o    = page_q;
  assign code_length_o     = typed_len_q;
  assign read_word_o       = rword_q;
  assign status_o          = status_q;

  // Prefix match of the entry read back against the typed code.
  always_comb begin
    logic [SYM_W-1:0] t, e;
    match = (dict_rd_q.len >= typed_len_q);
    for (int k = 0; k < MAX_CODE_LEN; k++) begin
      t = typed_code_q[k*SYM_W +: SYM_W];
      e = dict_rd_q.code[k*SYM_W +: SYM_W];
      if ((LEN_W'(k) < typed_len_q) && (t != SYM_WILD) && (t != e)) begin
        match = 1'b0;
      end
    end
  end

  // Typed code after a stroke or a backspace.
  always_comb begin
    stroke_code = typed_code_q;
    back_len    = typed_len_q - LEN_W'(1);
    back_code   = typed_code_q;
    for (int k = 0; k < MAX_CODE_LEN; k++) begin
      if (LEN_W'(k) == typed_len_q) begin
        stroke_code[k*SYM_W +: SYM_W] = stroke_i;
      end
      if (LEN_W'(k) == back_len) begin
        back_code[k*SYM_W +: SYM_W] = '0;
      end
    end
  end

  // Selection moves, paging and digit positions.
  always_comb begin
    down_sel  = ((CNT_W'(sel_q) + CNT_W'(1)) >= cand_count_q) ? '0 : sel_q + DICT_AW'(1);
    up_sel    = (sel_q == '0) ? DICT_AW'(cand_count_q - CNT_W'(1)) : sel_q - DICT_AW'(1);
    down_prod = (DICT_AW+12)'(down_sel) * (DICT_AW+12)'(DIV10_MUL);
    up_prod   = (DICT_AW+12)'(up_sel) * (DICT_AW+12)'(DIV10_MUL);
    next_page = (PAGE_W+1)'(page_q) + (PAGE_W+1)'(1);
    next_base = (PAGE_W+5)'(next_page) * (PAGE_W+5)'(PAGE_SIZE);
    page_base = (PAGE_W+5)'(page_q) * (PAGE_W+5)'(PAGE_SIZE);
    digit_idx = (digit_i == 4'd0) ? page_base
              : page_base + (PAGE_W+5)'(PAGE_SIZE) - (PAGE_W+5)'(digit_i);
  end

  // Memory port control.
  always_comb begin
    load_ok    = (dict_count_q < CNT_W'(DICT_DEPTH)) && (entry_code_len_i <= LEN_W'(MAX_CODE_LEN));
    dict_we    = (state_q == S_IDLE) && start_i && (op_i == OP_LOAD) && load_ok;
    issue      = ((state_q == S_SCAN) && (cnt_q < dict_count_q))
              || ((state_q == S_SORT) && (cnt_q < cand_count_q));
    src_data   = pass_q[0] ? b_rd_q : a_rd_q;
    sort_bit   = src_data.freq[pass_q];
    dict_raddr = (state_q == S_LK2) ? a_rd_q.idx : cnt_q[DICT_AW-1:0];
    a_raddr    = (state_q == S_SORT) ? cnt_q[DICT_AW-1:0] : pos_q;
    a_waddr    = wp_q[DICT_AW-1:0];
    a_we       = 1'b0;
    b_we       = 1'b0;
    a_wdata    = src_data;
    b_wdata    = src_data;
    if ((state_q == S_SCAN) && vld_q && match) begin
      a_we    = 1'b1;
      a_wdata = '{freq: dict_rd_q.freq, idx: vidx_q};
    end
    if ((state_q == S_SORT) && vld_q && (sort_bit == ph_q)) begin
      a_we = pass_q[0];
      b_we = !pass_q[0];
    end
  end

  // Dictionary memory.
  always_ff @(posedge clk_i) begin
    if (dict_we) begin
      dict_mem[dict_count_q[DICT_AW-1:0]] <= '{word: entry_word_i, code: entry_code_i,
                                               len: entry_code_len_i, freq: entry_freq_i};
    end
    dict_rd_q <= dict_mem[dict_raddr];
  end

  // Candidate list memories, ping-pong during the sort; the list ends in A.
  always_ff @(posedge clk_i) begin
    if (a_we) begin
      a_mem[a_waddr] <= a_wdata;
    end
    a_rd_q <= a_mem[a_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (b_we) begin
      b_mem[wp_q[DICT_AW-1:0]] <= b_wdata;
    end
    b_rd_q <= b_mem[cnt_q[DICT_AW-1:0]];
  end

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      done_q       <= 1'b0;
      dict_count_q <= '0;
      typed_code_q <= '0;
      typed_len_q  <= '0;
      cand_count_q <= '0;
      page_q       <= '0;
      sel_q        <= '0;
      cnt_q        <= '0;
      wp_q         <= '0;
      vld_q        <= 1'b0;
      vidx_q       <= '0;
      pass_q       <= '0;
      ph_q         <= 1'b0;
      pos_q        <= '0;
      is_commit_q  <= 1'b0;
      cvalid_q     <= 1'b0;
      cword_q      <= '0;
      del_q        <= 1'b0;
      rword_q      <= '0;
      status_q     <= ST_DONE;
    end else begin
      done_q <= 1'b0;
      vld_q  <= issue;
      vidx_q <= cnt_q[DICT_AW-1:0];
      if (issue) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (a_we || b_we) begin
        wp_q <= wp_q + CNT_W'(1);
      end
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            cvalid_q <= 1'b0;
            cword_q  <= '0;
            del_q    <= 1'b0;
            rword_q  <= '0;
            status_q <= ST_DONE;
            done_q   <= 1'b1;
            case (op_i)
              OP_LOAD: begin
                if (load_ok) begin
                  dict_count_q <= dict_count_q + CNT_W'(1);
                end else begin
                  status_q <= ST_DROPPED;
                end
              end
              OP_STROKE: begin
                if (stroke_i > SYM_WILD) begin
                  status_q <= ST_IGNORED;
                end else if (typed_len_q >= LEN_W'(MAX_CODE_LEN)) begin
                  status_q <= ST_DROPPED;
                end else begin
                  typed_code_q <= stroke_code;
                  typed_len_q  <= typed_len_q + LEN_W'(1);
                  cand_count_q <= '0;
                  page_q       <= '0;
                  sel_q        <= '0;
                  cnt_q        <= '0;
                  wp_q         <= '0;
                  done_q       <= 1'b0;
                  state_q      <= S_SCAN;
                end
              end
              OP_BACK: begin
                if (typed_len_q != '0) begin
                  typed_code_q <= back_code;
                  typed_len_q  <= back_len;
                  cand_count_q <= '0;
                  page_q       <= '0;
                  sel_q        <= '0;
                  cnt_q        <= '0;
                  wp_q         <= '0;
                  if (back_len != '0) begin
                    done_q  <= 1'b0;
                    state_q <= S_SCAN;
                  end
                end else begin
                  del_q <= 1'b1;
                end
              end
              OP_COMMIT: begin
                if (cand_count_q != '0) begin
                  pos_q       <= sel_q;
                  is_commit_q <= 1'b1;
                  done_q      <= 1'b0;
                  state_q     <= S_LK1;
                end else begin
                  status_q <= ST_IGNORED;
                end
              end
              OP_DIGIT: begin
                if ((digit_i <= 4'd9) && ((PAGE_W+5)'(cand_count_q) > digit_idx)) begin
                  pos_q       <= digit_idx[DICT_AW-1:0];
                  is_commit_q <= 1'b1;
                  done_q      <= 1'b0;
                  state_q     <= S_LK1;
                end else begin
                  status_q <= ST_IGNORED;
                end
              end
              OP_NEXT: begin
                if (next_base < (PAGE_W+5)'(cand_count_q)) begin
                  page_q <= next_page[PAGE_W-1:0];
                  sel_q  <= next_base[DICT_AW-1:0];
                end else begin
                  status_q <= ST_IGNORED;
                end
              end
              OP_PRIOR: begin
                if (page_q != '0) begin
                  page_q <= page_q - PAGE_W'(1);
                  sel_q  <= DICT_AW'(page_base - (PAGE_W+5)'(PAGE_SIZE));
                end else begin
                  status_q <= ST_IGNORED;
                end
              end
              OP_DOWN: begin
                if (cand_count_q != '0) begin
                  sel_q  <= down_sel;
                  page_q <= down_prod[DIV10_SHIFT +: PAGE_W];
                end else begin
                  status_q <= ST_IGNORED;
                end
              end
              OP_UP: begin
                if (cand_count_q != '0) begin
                  sel_q  <= up_sel;
                  page_q <= up_prod[DIV10_SHIFT +: PAGE_W];
                end else begin
                  status_q <= ST_IGNORED;
                end
              end
              OP_READ: begin
                if (CNT_W'(read_index_i) < cand_count_q) begin
                  pos_q       <= read_index_i;
                  is_commit_q <= 1'b0;
                  done_q      <= 1'b0;
                  state_q     <= S_LK1;
                end else begin
                  status_q <= ST_IGNORED;
                end
              end
              default: begin
                status_q <= ST_IGNORED;
              end
            endcase
          end
        end
        // Sweep the dictionary and append matches to list A.
        S_SCAN: begin
          if (!issue && !vld_q) begin
            cand_count_q <= wp_q;
            cnt_q        <= '0;
            wp_q         <= '0;
            pass_q       <= '0;
            ph_q         <= 1'b0;
            if (wp_q > CNT_W'(1)) begin
              state_q <= S_SORT;
            end else begin
              done_q  <= 1'b1;
              state_q <= S_IDLE;
            end
          end
        end
        // Stable radix-2 sort: zeros then ones of the key bit, per pass.
        S_SORT: begin
          if (!issue && !vld_q) begin
            cnt_q <= '0;
            if (!ph_q) begin
              ph_q <= 1'b1;
            end else begin
              ph_q   <= 1'b0;
              wp_q   <= '0;
              pass_q <= pass_q + 4'd1;
              if (pass_q == 4'(FREQ_W - 1)) begin
                done_q  <= 1'b1;
                state_q <= S_IDLE;
              end
            end
          end
        end
        // Candidate list read is in flight.
        S_LK1: begin
          state_q <= S_LK2;
        end
        // Dictionary read of the candidate is in flight.
        S_LK2: begin
          state_q <= S_LK3;
        end
        S_LK3: begin
          done_q  <= 1'b1;
          state_q <= S_IDLE;
          if (is_commit_q) begin
            cvalid_q     <= 1'b1;
            cword_q      <= dict_rd_q.word;
            typed_code_q <= '0;
            typed_len_q  <= '0;
            cand_count_q <= '0;
            page_q       <= '0;
            sel_q        <= '0;
          end else begin
            rword_q <= dict_rd_q.word;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[dv/stroke_code_candidate_selector_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Stroke code candidate selector testbench
// Drives dictionary loads, strokes, paging, selection, commits and reads.
// Every result is compared field by field against a behavioral predictor that
// keeps its own dictionary, typed code and candidate list.
// ----------------------------------------------------------------------------
module stroke_code_candidate_selector_tb;
  import sccs_pkg::*;

  // One input transaction.
  typedef struct {
    logic [3:0]        op;
    logic [2:0]        stroke;
    logic [3:0]        digit;
    logic [WORD_W-1:0] word;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
    logic [FREQ_W-1:0] freq;
    logic [DICT_AW-1:0] ridx;
  } key_item_t;

  // One result transaction.
  typedef struct {
    logic               cvalid;
    logic [WORD_W-1:0]  cword;
    logic               del;
    logic [CNT_W-1:0]   count;
    logic [DICT_AW-1:0] sel;
    logic [PAGE_W-1:0]  page;
    logic [LEN_W-1:0]   clen;
    logic [WORD_W-1:0]  rword;
    logic [1:0]         status;
  } key_result_t;

  // Directed row: item, whether a typed status is checked, and that status.
  typedef struct {
    key_item_t  item;
    bit         has_status;
    logic [1:0] status;
  } directed_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o, done_o;
  logic [3:0]         op_i = '0;
  logic [2:0]         stroke_i = '0;
  logic [3:0]         digit_i = '0;
  logic [WORD_W-1:0]  entry_word_i = '0;
  logic [CODE_W-1:0]  entry_code_i = '0;
  logic [LEN_W-1:0]   entry_code_len_i = '0;
  logic [FREQ_W-1:0]  entry_freq_i = '0;
  logic [DICT_AW-1:0] read_index_i = '0;
  logic               commit_valid_o, delete_last_o;
  logic [WORD_W-1:0]  commit_word_o, read_word_o;
  logic [CNT_W-1:0]   candidate_count_o;
  logic [DICT_AW-1:0] selected_index_o;
  logic [PAGE_W-1:0]  current_page_o;
  logic [LEN_W-1:0]   code_length_o;
  logic [1:0]         status_o;

  // Predictor state.
  logic [WORD_W-1:0]  lex_word [DICT_DEPTH];
  logic [CODE_W-1:0]  lex_code [DICT_DEPTH];
  logic [LEN_W-1:0]   lex_len  [DICT_DEPTH];
  logic [FREQ_W-1:0]  lex_freq [DICT_DEPTH];
  int                 lex_count;
  logic [CODE_W-1:0]  typed;
  int                 typed_len;
  int                 cand [$];
  int                 page_pos, sel_pos;

  key_result_t        pending_keys [$];
  int                 error_count = 0;
  int                 result_count = 0;

  stroke_code_candidate_selector dut (.*);

  always #2 clk_i = ~clk_i;

  // Rebuild the candidate list: wildcard prefix match, stable by frequency.
  task automatic refresh_candidates();
    int      n;
    bit      ok;
    logic [2:0] t;
    cand.delete();
    page_pos = 0;
    sel_pos  = 0;
    if (typed_len == 0) return;
    for (int i = 0; i < lex_count; i++) begin
      ok = lex_len[i] >= typed_len;
      for (int k = 0; ok && k < typed_len; k++) begin
        t = typed[SYM_W*k +: SYM_W];
        if (t != SYM_WILD && t != lex_code[i][SYM_W*k +: SYM_W]) ok = 0;
      end
      if (ok) begin
        n = cand.size();
        while (n > 0 && lex_freq[cand[n-1]] > lex_freq[i]) n--;
        cand.insert(n, i);
      end
    end
  endtask

  function automatic logic [WORD_W-1:0] cand_word(int pos);
    if (pos < cand.size()) return lex_word[cand[pos]];
    return '0;
  endfunction

  task automatic clear_typing();
    typed = '0;
    typed_len = 0;
    cand.delete();
    page_pos = 0;
    sel_pos = 0;
  endtask

  // Predict the result of one transaction and queue it.
  task automatic predict_key(input key_item_t it);
    key_result_t r;
    int          idx;
    r = '{default: '0};
    case (it.op)
      OP_LOAD: begin
        if (lex_count >= DICT_DEPTH || it.len > MAX_CODE_LEN) r.status = ST_DROPPED;
        else begin
          lex_word[lex_count] = it.word;
          lex_code[lex_count] = it.code;
          lex_len[lex_count]  = it.len;
          lex_freq[lex_count] = it.freq;
          lex_count++;
        end
      end
      OP_STROKE: begin
        if (it.stroke > SYM_WILD) r.status = ST_IGNORED;
        else if (typed_len >= MAX_CODE_LEN) r.status = ST_DROPPED;
        else begin
          typed[SYM_W*typed_len +: SYM_W] = it.stroke;
          typed_len++;
          refresh_candidates();
        end
      end
      OP_BACK: begin
        if (typed_len > 0) begin
          typed_len--;
          typed[SYM_W*typed_len +: SYM_W] = '0;
          refresh_candidates();
        end else r.del = 1'b1;
      end
      OP_COMMIT: begin
        if (cand.size() > 0) begin
          r.cvalid = 1'b1;
          r.cword = cand_word(sel_pos);
          clear_typing();
        end else r.status = ST_IGNORED;
      end
      OP_DIGIT: begin
        idx = page_pos * PAGE_SIZE;
        if (it.digit > 9) r.status = ST_IGNORED;
        else begin
          if (it.digit != 0) idx += PAGE_SIZE - it.digit;
          if (idx < cand.size()) begin
            r.cvalid = 1'b1;
            r.cword = cand_word(idx);
            clear_typing();
          end else r.status = ST_IGNORED;
        end
      end
      OP_NEXT: begin
        if ((page_pos + 1) * PAGE_SIZE < cand.size()) begin
          page_pos++;
          sel_pos = page_pos * PAGE_SIZE;
        end else r.status = ST_IGNORED;
      end
      OP_PRIOR: begin
        if (page_pos > 0) begin
          page_pos--;
          sel_pos = page_pos * PAGE_SIZE;
        end else r.status = ST_IGNORED;
      end
      OP_DOWN: begin
        if (cand.size() > 0) begin
          sel_pos++;
          if (sel_pos >= cand.size()) sel_pos = 0;
          page_pos = sel_pos / PAGE_SIZE;
        end else r.status = ST_IGNORED;
      end
      OP_UP: begin
        if (cand.size() > 0) begin
          sel_pos = (sel_pos == 0) ? cand.size() - 1 : sel_pos - 1;
          page_pos = sel_pos / PAGE_SIZE;
        end else r.status = ST_IGNORED;
      end
      OP_READ: begin
        if (it.ridx < cand.size()) r.rword = cand_word(it.ridx);
        else r.status = ST_IGNORED;
      end
      default: r.status = ST_IGNORED;
    endcase
    r.count = CNT_W'(cand.size());
    r.sel   = DICT_AW'(sel_pos);
    r.page  = PAGE_W'(page_pos);
    r.clen  = LEN_W'(typed_len);
    pending_keys = {pending_keys, r};
  endtask

  task automatic report_mismatch(input string what);
    $display("tb: mismatch on result %0d: %s", result_count, what);
    error_count++;
  endtask

  // Check each result against the oldest expectation.
  always @(posedge clk_i) begin
    key_result_t e;
    if (rst_ni && done_o) begin
      if (pending_keys.size() == 0) report_mismatch("result with nothing expected");
      else begin
        e = pending_keys.pop_front();
        if (commit_valid_o !== e.cvalid) report_mismatch("commit_valid");
        if (commit_word_o !== e.cword) report_mismatch("commit_word");
        if (delete_last_o !== e.del) report_mismatch("delete_last");
        if (candidate_count_o !== e.count) report_mismatch("candidate_count");
        if (selected_index_o !== e.sel) report_mismatch("selected_index");
        if (current_page_o !== e.page) report_mismatch("current_page");
        if (code_length_o !== e.clen) report_mismatch("code_length");
        if (read_word_o !== e.rword) report_mismatch("read_word");
        if (status_o !== e.status) report_mismatch("status");
      end
      result_count++;
    end
  end

  // Send one transaction after a random gap; the typed status is checked
  // against the predictor's status once it is queued. The task returns at
  // the accepting edge with start_i still high; idle_inputs lowers it at the
  // following falling edge, and so does the next call when its gap is not zero.
  task automatic send_key(input key_item_t it, input bit has_status = 0,
                          input logic [1:0] want = ST_DONE);
    int gap;
    gap = $urandom_range(0, 3);
    @(negedge clk_i);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    predict_key(it);
    if (has_status && pending_keys[$].status !== want)
      report_mismatch("directed status differs from prediction");
    op_i <= it.op; stroke_i <= it.stroke; digit_i <= it.digit;
    entry_word_i <= it.word; entry_code_i <= it.code;
    entry_code_len_i <= it.len; entry_freq_i <= it.freq;
    read_index_i <= it.ridx;
    start_i <= 1'b1;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  // Stop requesting after the last accepted transaction.
  task automatic idle_inputs();
    @(negedge clk_i);
    start_i <= 1'b0;
  endtask

  function automatic key_item_t mk(logic [3:0] op, logic [2:0] s = 0, logic [3:0] d = 0,
                                   logic [WORD_W-1:0] w = 0, logic [CODE_W-1:0] c = 0,
                                   logic [LEN_W-1:0] l = 0, logic [FREQ_W-1:0] f = 0,
                                   logic [DICT_AW-1:0] r = 0);
    key_item_t it;
    it.op = op; it.stroke = s; it.digit = d; it.word = w;
    it.code = c; it.len = l; it.freq = f; it.ridx = r;
    return it;
  endfunction

  // Random entry whose code uses only strokes 0..1 in the first symbols,
  // so short typed prefixes hit many entries.
  function automatic key_item_t rand_entry();
    logic [CODE_W-1:0] c;
    c = {$urandom, $urandom};
    for (int k = 0; k < 4; k++) c[SYM_W*k +: SYM_W] = SYM_W'($urandom_range(0, 1));
    return mk(OP_LOAD, 0, 0, $urandom, c, LEN_W'($urandom_range(1, MAX_CODE_LEN)),
              FREQ_W'($urandom_range(0, 7)));
  endfunction

  directed_row_t rows [$];

  initial begin
    key_item_t it;
    int        pick;
    lex_count = 0;
    clear_typing();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table: empty-state cases, extremes, and a small dictionary.
    rows = '{
      '{mk(OP_BACK), 1, ST_DONE},
      '{mk(OP_COMMIT), 1, ST_IGNORED},
      '{mk(OP_DIGIT, 0, 0), 1, ST_IGNORED},
      '{mk(OP_NEXT), 1, ST_IGNORED},
      '{mk(OP_PRIOR), 1, ST_IGNORED},
      '{mk(OP_DOWN), 1, ST_IGNORED},
      '{mk(OP_UP), 1, ST_IGNORED},
      '{mk(OP_READ, 0, 0, 0, 0, 0, 0, '1), 1, ST_IGNORED},
      '{mk(4'd15), 1, ST_IGNORED},
      '{mk(OP_LOAD, 0, 0, '1, '1, 5'd17, '1), 1, ST_DROPPED},
      '{mk(OP_LOAD, 0, 0, '1, '1, 5'd31, 0), 1, ST_DROPPED},
      '{mk(OP_LOAD, 0, 0, '1, '0, LEN_W'(MAX_CODE_LEN), '1), 1, ST_DONE},
      '{mk(OP_LOAD, 0, 0, 32'h1234, {16{3'd4}}, LEN_W'(MAX_CODE_LEN), 0), 1, ST_DONE},
      '{mk(OP_LOAD, 0, 0, 32'h5678, '0, 5'd0, 16'd3), 1, ST_DONE},
      '{mk(OP_STROKE, 3'd7), 1, ST_IGNORED},
      '{mk(OP_STROKE, 3'd6), 1, ST_IGNORED},
      '{mk(OP_STROKE, SYM_WILD), 1, ST_DONE},
      '{mk(OP_LOAD, 0, 0, 32'h9, '0, 5'd2, 16'd1), 1, ST_DONE},
      '{mk(OP_READ, 0, 0, 0, 0, 0, 0, 12'd1), 1, ST_DONE},
      '{mk(OP_DIGIT, 0, 4'd15), 1, ST_IGNORED},
      '{mk(OP_DIGIT, 0, 4'd9), 1, ST_DONE},
      '{mk(OP_STROKE, 3'd0), 0, ST_DONE},
      '{mk(OP_UP), 0, ST_DONE},
      '{mk(OP_COMMIT), 0, ST_DONE}
    };
    foreach (rows[i]) send_key(rows[i].item, rows[i].has_status, rows[i].status);

    // Fill the code to its limit and past it, then back out.
    for (int i = 0; i <= MAX_CODE_LEN; i++) send_key(mk(OP_STROKE, 3'd4));
    send_key(mk(OP_BACK));
    send_key(mk(OP_DIGIT, 0, 0));

    // Random part: loads mixed at random with typing, paging, selection and reads.
    for (int n = 0; n < 60; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) it = rand_entry();
      else if (pick < 50) it = mk(OP_STROKE, SYM_W'($urandom_range(0, 9) < 8 ?
                                 $urandom_range(0, 1) : $urandom_range(0, 7)));
      else if (pick < 57) it = mk(OP_BACK);
      else if (pick < 62) it = mk(OP_COMMIT);
      else if (pick < 68) it = mk(OP_DIGIT, 0, 4'($urandom_range(0, 9) < 9 ?
                                 $urandom_range(0, 9) : $urandom_range(0, 15)));
      else if (pick < 74) it = mk(OP_NEXT);
      else if (pick < 78) it = mk(OP_PRIOR);
      else if (pick < 84) it = mk(OP_DOWN);
      else if (pick < 89) it = mk(OP_UP);
      else if (pick < 97) it = mk(OP_READ, 0, 0, 0, 0, 0, 0,
                                  DICT_AW'($urandom_range(0, 3) == 0 ?
                                           $urandom : $urandom_range(0, 40)));
      else it = mk(4'($urandom_range(10, 15)), 3'($urandom), 4'($urandom));
      send_key(it);
      if (n == 30) begin
        idle_inputs();
        while (pending_keys.size() != 0) @(posedge clk_i);
      end
    end

    idle_inputs();
    while (pending_keys.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (error_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  // Watchdog.
  initial begin
    #40ms;
    $display("tb: failure");
    $finish;
  end

endmodule

[filelist.f]
hdl/sccs_pkg.sv
hdl/stroke_code_candidate_selector.sv
dv/stroke_code_candidate_selector_tb.sv
